[rtl/stuffed_frame_receiver_macros.svh]
// Assertion helpers for the receiver RTL.
`ifndef STUFFED_FRAME_RECEIVER_MACROS_SVH
`define STUFFED_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("stuffed_frame_receiver: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("stuffed_frame_receiver: next-cycle check failed");

`endif

[rtl/sfr_pkg.sv]
package sfr_pkg;

  // Default body length limit of a frame.
  localparam int MAX_FRAME_BYTES_DEF = 256;

  // A stuffed byte is the original code xor this mask.
  localparam logic [7:0] STUFF_MASK = 8'h20;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_FLAG         = 3'd0,
    CFG_ADDRESS      = 3'd1,
    CFG_ESCAPE       = 3'd2,
    CFG_SET          = 3'd3,
    CFG_INFO         = 3'd4,
    CFG_FINAL        = 3'd5,
    CFG_DISC         = 3'd6,
    CFG_ACCEPT_FINAL = 3'd7
  } cfg_idx_t;

  // Event codes of a result beat.
  typedef enum logic [2:0] {
    EV_PAYLOAD  = 3'd0,
    EV_SET      = 3'd1,
    EV_DONE     = 3'd2,
    EV_DISC     = 3'd3,
    EV_ABORT    = 3'd4,
    EV_OVERFLOW = 3'd5
  } ev_kind_t;

  // Parser states.
  typedef enum logic [3:0] {
    ST_HUNT     = 4'd0,
    ST_ADDR     = 4'd1,
    ST_CTRL     = 4'd2,
    ST_SET_CHK  = 4'd3,
    ST_SET_END  = 4'd4,
    ST_HDR_CHK  = 4'd5,
    ST_BODY     = 4'd6,
    ST_HELD     = 4'd7,
    ST_DISC_CHK = 4'd8,
    ST_DISC_END = 4'd9
  } parse_state_t;

  // Link configuration as seen by the parser.
  typedef struct packed {
    logic [7:0] flag_code;
    logic [7:0] address_code;
    logic [7:0] escape_code;
    logic [7:0] set_code;
    logic [7:0] info_code;
    logic [7:0] final_code;
    logic [7:0] disc_code;
    logic       accept_final;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    ev_kind_t   event_kind;
    logic [7:0] payload;
    logic       frame_type;
    logic [8:0] frame_length;
    logic       last;
  } res_t;

endpackage

[rtl/sfr_parser.sv]
module sfr_parser #(
  parameter int MAX_FRAME_BYTES = sfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    line_byte,
  input  sfr_pkg::cfg_t cfg,
  output sfr_pkg::res_t res0,
  output sfr_pkg::res_t res1,
  output logic [1:0]    push_n
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int EXT_W = CNT_W + 9;

  sfr_pkg::parse_state_t st_r, st_nxt;
  logic [7:0]       prev_r, prev_nxt;
  logic             esc_r, esc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             type_r, type_nxt;
  logic             link_r, link_nxt;

  logic [7:0] b;
  logic [7:0] chk_i, chk_f, chk_set, chk_disc, stuffed_flag, stuffed_esc, unstuffed;
  logic       ovf0, ovf1;
  logic [EXT_W-1:0] cnt_ext;
  logic [1:0] n;
  sfr_pkg::res_t r0, r1;

  function automatic sfr_pkg::res_t mk_res(sfr_pkg::ev_kind_t k, logic [7:0] d,
                                           logic t, logic [8:0] len);
    sfr_pkg::res_t r;
    r.event_kind   = k;
    r.payload      = d;
    r.frame_type   = t;
    r.frame_length = len;
    r.last         = 1'b0;
    return r;
  endfunction

  // Derived compare values.
  assign b            = line_byte;
  assign chk_i        = cfg.address_code ^ cfg.info_code;
  assign chk_f        = cfg.address_code ^ cfg.final_code;
  assign chk_set      = cfg.address_code ^ cfg.set_code;
  assign chk_disc     = cfg.address_code ^ cfg.disc_code;
  assign stuffed_flag = cfg.flag_code ^ sfr_pkg::STUFF_MASK;
  assign stuffed_esc  = cfg.escape_code ^ sfr_pkg::STUFF_MASK;
  assign unstuffed    = (b == stuffed_flag) ? cfg.flag_code : cfg.escape_code;
  assign ovf0         = (cnt_r >= CNT_W'(MAX_FRAME_BYTES));
  assign ovf1         = (cnt_r >= CNT_W'(MAX_FRAME_BYTES - 1));
  assign cnt_ext      = EXT_W'(cnt_r);

  // Next state and results for the byte in the input register.
  always_comb begin
    st_nxt   = st_r;
    prev_nxt = prev_r;
    esc_nxt  = esc_r;
    cnt_nxt  = cnt_r;
    type_nxt = type_r;
    link_nxt = link_r;
    n        = 2'd0;
    r0       = mk_res(sfr_pkg::EV_PAYLOAD, 8'd0, 1'b0, 9'd0);
    r1       = mk_res(sfr_pkg::EV_PAYLOAD, 8'd0, 1'b0, 9'd0);
    unique case (st_r)
      sfr_pkg::ST_ADDR: begin
        if (b == cfg.address_code) begin
          st_nxt = sfr_pkg::ST_CTRL;
        end else if (b != cfg.flag_code) begin
          st_nxt = sfr_pkg::ST_HUNT;
        end
        cnt_nxt  = '0;
        prev_nxt = 8'd0;
        esc_nxt  = 1'b0;
      end
      sfr_pkg::ST_CTRL: begin
        priority if (b == cfg.set_code) begin
          st_nxt = sfr_pkg::ST_SET_CHK;
        end else if (b == cfg.info_code && link_r) begin
          st_nxt = sfr_pkg::ST_HDR_CHK;
        end else if (b == cfg.final_code && cfg.accept_final && link_r) begin
          st_nxt = sfr_pkg::ST_HDR_CHK;
        end else if (b == cfg.disc_code) begin
          st_nxt = sfr_pkg::ST_DISC_CHK;
        end else if (b == cfg.flag_code) begin
          st_nxt = sfr_pkg::ST_ADDR;
        end else begin
          st_nxt = sfr_pkg::ST_HUNT;
        end
      end
      sfr_pkg::ST_SET_CHK: begin
        priority if (b == chk_set) begin
          st_nxt = sfr_pkg::ST_SET_END;
        end else if (b == cfg.flag_code) begin
          st_nxt = sfr_pkg::ST_ADDR;
        end else begin
          st_nxt = sfr_pkg::ST_HUNT;
        end
      end
      sfr_pkg::ST_SET_END: begin
        if (b == cfg.flag_code) begin
          link_nxt = 1'b1;
          r0       = mk_res(sfr_pkg::EV_SET, 8'd0, 1'b0, 9'd0);
          n        = 2'd1;
        end
        st_nxt = sfr_pkg::ST_HUNT;
      end
      sfr_pkg::ST_HDR_CHK: begin
        priority if (b == chk_i) begin
          st_nxt   = sfr_pkg::ST_BODY;
          type_nxt = 1'b0;
        end else if (b == chk_f) begin
          st_nxt   = sfr_pkg::ST_BODY;
          type_nxt = 1'b1;
        end else if (b == cfg.flag_code) begin
          st_nxt = sfr_pkg::ST_ADDR;
        end else begin
          st_nxt = sfr_pkg::ST_HUNT;
        end
        prev_nxt = b;
        esc_nxt  = (b == cfg.escape_code);
      end
      sfr_pkg::ST_BODY: begin
        priority if (b == cfg.flag_code) begin
          // A flag inside the body aborts the frame.
          r0     = mk_res(sfr_pkg::EV_ABORT, 8'd0, 1'b0, 9'd0);
          n      = 2'd1;
          st_nxt = sfr_pkg::ST_ADDR;
        end else if (b == stuffed_flag || b == stuffed_esc || !(b == cfg.escape_code
                     || b == chk_i || b == chk_f)) begin
          // Ordinary or stuffed body byte.
          n = 2'd1;
          if (ovf0) begin
            r0       = mk_res(sfr_pkg::EV_OVERFLOW, 8'd0, 1'b0, 9'd0);
            st_nxt   = sfr_pkg::ST_HUNT;
            cnt_nxt  = '0;
            esc_nxt  = 1'b0;
            prev_nxt = 8'd0;
          end else begin
            cnt_nxt = CNT_W'(cnt_r + CNT_W'(1));
            if (esc_r && (b == stuffed_flag || b == stuffed_esc)) begin
              r0       = mk_res(sfr_pkg::EV_PAYLOAD, unstuffed, 1'b0, 9'd0);
              prev_nxt = 8'd0;
              esc_nxt  = 1'b0;
            end else begin
              r0       = mk_res(sfr_pkg::EV_PAYLOAD, b, 1'b0, 9'd0);
              prev_nxt = b;
              esc_nxt  = (b == cfg.escape_code);
            end
          end
        end else if (b == cfg.escape_code) begin
          prev_nxt = b;
          esc_nxt  = 1'b1;
        end else begin
          // Possible closing check byte: hold it until the next byte.
          st_nxt   = sfr_pkg::ST_HELD;
          prev_nxt = b;
          esc_nxt  = (b == cfg.escape_code);
        end
      end
      sfr_pkg::ST_HELD: begin
        if (b == cfg.flag_code) begin
          r0 = mk_res(sfr_pkg::EV_DONE, 8'd0, type_r, cnt_ext[8:0]);
          n        = 2'd1;
          st_nxt   = sfr_pkg::ST_HUNT;
          prev_nxt = 8'd0;
          esc_nxt  = 1'b0;
        end else if (ovf0) begin
          r0       = mk_res(sfr_pkg::EV_OVERFLOW, 8'd0, 1'b0, 9'd0);
          n        = 2'd1;
          st_nxt   = sfr_pkg::ST_HUNT;
          cnt_nxt  = '0;
          esc_nxt  = 1'b0;
          prev_nxt = 8'd0;
        end else begin
          // Release the held byte, then take this byte raw.
          r0 = mk_res(sfr_pkg::EV_PAYLOAD, prev_r, 1'b0, 9'd0);
          n  = 2'd2;
          if (ovf1) begin
            r1       = mk_res(sfr_pkg::EV_OVERFLOW, 8'd0, 1'b0, 9'd0);
            st_nxt   = sfr_pkg::ST_HUNT;
            cnt_nxt  = '0;
            esc_nxt  = 1'b0;
            prev_nxt = 8'd0;
          end else begin
            r1       = mk_res(sfr_pkg::EV_PAYLOAD, b, 1'b0, 9'd0);
            cnt_nxt  = CNT_W'(cnt_r + CNT_W'(2));
            prev_nxt = b;
            esc_nxt  = (b == cfg.escape_code);
            st_nxt   = sfr_pkg::ST_BODY;
          end
        end
      end
      sfr_pkg::ST_DISC_CHK: begin
        priority if (b == chk_disc) begin
          st_nxt = sfr_pkg::ST_DISC_END;
        end else if (b == cfg.flag_code) begin
          st_nxt = sfr_pkg::ST_ADDR;
        end else begin
          st_nxt = sfr_pkg::ST_HUNT;
        end
      end
      sfr_pkg::ST_DISC_END: begin
        if (b == cfg.flag_code) begin
          r0 = mk_res(sfr_pkg::EV_DISC, 8'd0, 1'b0, 9'd0);
          n  = 2'd1;
        end
        st_nxt = sfr_pkg::ST_HUNT;
      end
      default: begin
        // Hunting for a flag; unused codes behave the same way.
        st_nxt  = (b == cfg.flag_code) ? sfr_pkg::ST_ADDR : sfr_pkg::ST_HUNT;
        cnt_nxt = '0;
      end
    endcase
    // Mark the final result of this byte.
    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign res0   = r0;
  assign res1   = r1;
  assign push_n = fire ? n : 2'd0;

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= sfr_pkg::ST_HUNT;
      prev_r <= 8'd0;
      esc_r  <= 1'b0;
      cnt_r  <= '0;
      type_r <= 1'b0;
      link_r <= 1'b0;
    end else if (fire) begin
      st_r   <= st_nxt;
      prev_r <= prev_nxt;
      esc_r  <= esc_nxt;
      cnt_r  <= cnt_nxt;
      type_r <= type_nxt;
      link_r <= link_nxt;
    end
  end

endmodule

[rtl/sfr_out_queue.sv]
module sfr_out_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  sfr_pkg::res_t res0,
  input  sfr_pkg::res_t res1,
  input  logic [1:0]    push_n,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output sfr_pkg::res_t head
);

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_LW    = $clog2(Q_DEPTH + 1);

  sfr_pkg::res_t q_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_LW-1:0] level_r;
  logic            pop;

  assign out_valid = (level_r != '0);
  assign pop       = out_valid && out_ready;
  assign head      = q_r[rd_ptr_r];
  // Room for the largest burst a single byte can produce.
  assign room      = (level_r <= Q_LW'(Q_DEPTH - 2));

  // Result storage.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      q_r[Q_AW'(wr_ptr_r + Q_AW'(1))] <= res1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= Q_AW'(wr_ptr_r + Q_AW'(push_n));
      if (pop) begin
        rd_ptr_r <= Q_AW'(rd_ptr_r + Q_AW'(1));
      end
      level_r <= Q_LW'(level_r + Q_LW'(push_n) - Q_LW'(pop));
    end
  end

endmodule

[rtl/stuffed_frame_receiver.sv]
// Byte-stuffed frame receiver. One line byte is taken per beat and the block
// sustains one byte per clock cycle while the result queue has room: a byte
// sits in the input register while the frame parser updates its state, and
// its results enter a four-entry result queue. Most bytes give at most one
// result; a released held check byte gives two, and then the output side
// needs two beats for that byte, which holds the input back only when the
// consumer is slower than one result per cycle. Configuration registers are
// written through the cfg_ port, one register per beat, and take effect for
// the next line byte.
`include "stuffed_frame_receiver_macros.svh"

module stuffed_frame_receiver #(
  parameter int MAX_FRAME_BYTES = sfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_line_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_event_kind,
  output logic [7:0] out_payload,
  output logic       out_frame_type,
  output logic [8:0] out_frame_length,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  sfr_pkg::cfg_t cfg_r;
  logic [7:0]    byte_r;
  logic          ivld_r;
  logic          fire, room;
  logic [1:0]    push_n;
  sfr_pkg::res_t res0, res1, head;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_code    <= 8'd126;
      cfg_r.address_code <= 8'd3;
      cfg_r.escape_code  <= 8'd125;
      cfg_r.set_code     <= 8'd3;
      cfg_r.info_code    <= 8'd0;
      cfg_r.final_code   <= 8'd64;
      cfg_r.disc_code    <= 8'd11;
      cfg_r.accept_final <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sfr_pkg::cfg_idx_t'(cfg_index))
        sfr_pkg::CFG_FLAG:         cfg_r.flag_code    <= cfg_data;
        sfr_pkg::CFG_ADDRESS:      cfg_r.address_code <= cfg_data;
        sfr_pkg::CFG_ESCAPE:       cfg_r.escape_code  <= cfg_data;
        sfr_pkg::CFG_SET:          cfg_r.set_code     <= cfg_data;
        sfr_pkg::CFG_INFO:         cfg_r.info_code    <= cfg_data;
        sfr_pkg::CFG_FINAL:        cfg_r.final_code   <= cfg_data;
        sfr_pkg::CFG_DISC:         cfg_r.disc_code    <= cfg_data;
        sfr_pkg::CFG_ACCEPT_FINAL: cfg_r.accept_final <= cfg_data[0];
        default:                   cfg_r.accept_final <= cfg_r.accept_final;
      endcase
    end
  end

  // Input register: refills in the same cycle its byte is parsed.
  assign fire     = ivld_r && room;
  assign in_ready = !ivld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      ivld_r <= 1'b1;
    end else if (fire) begin
      ivld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_line_byte;
    end
  end

  sfr_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .line_byte (byte_r),
    .cfg       (cfg_r),
    .res0      (res0),
    .res1      (res1),
    .push_n    (push_n)
  );

  sfr_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .res0      (res0),
    .res1      (res1),
    .push_n    (push_n),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // Result beat fields.
  assign out_event_kind   = head.event_kind;
  assign out_payload      = head.payload;
  assign out_frame_type   = head.frame_type;
  assign out_frame_length = head.frame_length;
  assign out_last         = head.last;

  // A two-result byte always starts with the released held byte.
  `SFR_ASSERT_NOW(a_pair_starts_payload, clk, rst_n, push_n == 2'd2, res0.event_kind == sfr_pkg::EV_PAYLOAD)
  // Results are only pushed for a byte that is being parsed.
  `SFR_ASSERT_NOW(a_push_needs_fire, clk, rst_n, !fire, push_n == 2'd0)
  // A byte accepted over a full input register must be the one that moves on.
  `SFR_ASSERT_NOW(a_no_overwrite, clk, rst_n, in_valid && in_ready && ivld_r, fire)

endmodule

[verif/stuffed_frame_receiver_tb.sv]
`timescale 1ns / 1ps

module stuffed_frame_receiver_tb;
  import sfr_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int BODY_LIMIT    = MAX_FRAME_BYTES_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AT_ITEM  = 60;
  localparam int RANDOM_ITEMS  = 240;
  localparam int PHASE_COUNT   = 6;
  localparam int PHASE_ITEMS   = RANDOM_ITEMS / PHASE_COUNT;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_LIMIT  = 10;
  localparam int SCRIPT_LEN    = 27;

  localparam cfg_t RESET_CFG = '{8'h7E, 8'h03, 8'h7D, 8'h03, 8'h00, 8'h40, 8'h0B, 1'b0};

  // One row of the directed script: a line byte and, where it is obvious,
  // the single result that byte must cause.
  typedef struct packed {
    logic [7:0] line_byte;
    logic       typed;
    ev_kind_t   kind;
    logic [8:0] length;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_line_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_event_kind;
  logic [7:0] out_payload;
  logic       out_frame_type;
  logic [8:0] out_frame_length;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = 3'd0;
  logic [7:0] cfg_data = 8'h00;

  // Parser image kept alongside the block.
  cfg_t         link_cfg = RESET_CFG;
  parse_state_t rx_state = ST_HUNT;
  logic [7:0]   prev_byte = 8'h00;
  logic         esc_pending = 1'b0;
  int unsigned  body_len = 0;
  logic         alt_type = 1'b0;
  logic         link_up = 1'b0;

  res_t step_results[$];
  res_t expected_events[$];

  int error_count = 0;
  int cycle_count = 0;
  int random_sent = 0;
  int send_idle_pct = 35;
  int recv_idle_pct = 45;
  bit stall_request = 1'b0;
  bit stall_done = 1'b0;

  // Directed script under the reset configuration.
  script_row_t script [0:SCRIPT_LEN-1] = '{
    // SET frame opens the link.
    '{8'h7E, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h03, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h03, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h00, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h7E, 1'b1, EV_SET, 9'd0},
    // Information frame header with the ordinary check value.
    '{8'h7E, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h03, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h00, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h03, 1'b0, EV_PAYLOAD, 9'd0},
    // Stuffed escape, then an escape followed by a plain byte.
    '{8'h7D, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h5D, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h7D, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'hFF, 1'b0, EV_PAYLOAD, 9'd0},
    // Held check byte released by a raw escape, which then stuffs a flag.
    '{8'h03, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h7D, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h5E, 1'b0, EV_PAYLOAD, 9'd0},
    // Alternate check value and flag close the frame with five body bytes.
    '{8'h43, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h7E, 1'b1, EV_DONE, 9'd5},
    // A flag inside the body aborts the frame.
    '{8'h7E, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h03, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h00, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h03, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h7E, 1'b1, EV_ABORT, 9'd0},
    // The abort flag doubles as the opening flag of a DISC frame.
    '{8'h03, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h0B, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h08, 1'b0, EV_PAYLOAD, 9'd0},
    '{8'h7E, 1'b1, EV_DISC, 9'd0}
  };

  stuffed_frame_receiver i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_line_byte     (in_line_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_payload      (out_payload),
    .out_frame_type   (out_frame_type),
    .out_frame_length (out_frame_length),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_events.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void add_result(ev_kind_t kind, logic [7:0] data, logic ftype,
                                     logic [8:0] len);
    res_t r;
    r.event_kind   = kind;
    r.payload      = data;
    r.frame_type   = ftype;
    r.frame_length = len;
    r.last         = 1'b0;
    step_results.push_back(r);
  endfunction

  // Appends a body byte, or reports overflow and drops back to hunting.
  function automatic bit take_body(logic [7:0] b);
    if (body_len >= BODY_LIMIT) begin
      add_result(EV_OVERFLOW, 8'h00, 1'b0, 9'd0);
      rx_state    = ST_HUNT;
      body_len    = 0;
      esc_pending = 1'b0;
      prev_byte   = 8'h00;
      return 1'b0;
    end
    add_result(EV_PAYLOAD, b, 1'b0, 9'd0);
    body_len++;
    return 1'b1;
  endfunction

  function automatic void note_byte(logic [7:0] b);
    prev_byte   = b;
    esc_pending = (b == link_cfg.escape_code);
  endfunction

  // Advances the parser image by one line byte and leaves its results
  // in step_results.
  function automatic void parse_line_byte(logic [7:0] b);
    logic [7:0] chk_info;
    logic [7:0] chk_final;
    logic [7:0] stuffed_flag;
    logic [7:0] stuffed_esc;
    chk_info     = link_cfg.address_code ^ link_cfg.info_code;
    chk_final    = link_cfg.address_code ^ link_cfg.final_code;
    stuffed_flag = link_cfg.flag_code ^ STUFF_MASK;
    stuffed_esc  = link_cfg.escape_code ^ STUFF_MASK;
    step_results.delete();
    case (rx_state)
      ST_ADDR: begin
        if (b == link_cfg.address_code) rx_state = ST_CTRL;
        else if (b != link_cfg.flag_code) rx_state = ST_HUNT;
        body_len    = 0;
        prev_byte   = 8'h00;
        esc_pending = 1'b0;
      end
      ST_CTRL: begin
        if (b == link_cfg.set_code) rx_state = ST_SET_CHK;
        else if (b == link_cfg.info_code && link_up) rx_state = ST_HDR_CHK;
        else if (b == link_cfg.final_code && link_cfg.accept_final && link_up)
          rx_state = ST_HDR_CHK;
        else if (b == link_cfg.disc_code) rx_state = ST_DISC_CHK;
        else if (b == link_cfg.flag_code) rx_state = ST_ADDR;
        else rx_state = ST_HUNT;
      end
      ST_SET_CHK: begin
        if (b == (link_cfg.address_code ^ link_cfg.set_code)) rx_state = ST_SET_END;
        else if (b == link_cfg.flag_code) rx_state = ST_ADDR;
        else rx_state = ST_HUNT;
      end
      ST_SET_END: begin
        if (b == link_cfg.flag_code) begin
          link_up = 1'b1;
          add_result(EV_SET, 8'h00, 1'b0, 9'd0);
        end
        rx_state = ST_HUNT;
      end
      ST_HDR_CHK: begin
        if (b == chk_info) begin
          rx_state = ST_BODY;
          alt_type = 1'b0;
        end else if (b == chk_final) begin
          rx_state = ST_BODY;
          alt_type = 1'b1;
        end else if (b == link_cfg.flag_code) begin
          rx_state = ST_ADDR;
        end else begin
          rx_state = ST_HUNT;
        end
        note_byte(b);
      end
      ST_BODY: begin
        // Order of tests decides between overlapping codes.
        if (b == link_cfg.flag_code) begin
          add_result(EV_ABORT, 8'h00, 1'b0, 9'd0);
          rx_state = ST_ADDR;
        end else if (b == stuffed_flag || b == stuffed_esc) begin
          if (esc_pending) begin
            if (take_body(b == stuffed_flag ? link_cfg.flag_code : link_cfg.escape_code)) begin
              prev_byte   = 8'h00;
              esc_pending = 1'b0;
            end
          end else if (take_body(b)) begin
            note_byte(b);
          end
        end else if (b == link_cfg.escape_code) begin
          prev_byte   = b;
          esc_pending = 1'b1;
        end else if (b == chk_info || b == chk_final) begin
          rx_state = ST_HELD;
          note_byte(b);
        end else if (take_body(b)) begin
          note_byte(b);
        end
      end
      ST_HELD: begin
        // A flag confirms the held byte as the closing check; anything else
        // releases it and is itself taken raw.
        if (b == link_cfg.flag_code) begin
          add_result(EV_DONE, 8'h00, alt_type, body_len[8:0]);
          rx_state    = ST_HUNT;
          prev_byte   = 8'h00;
          esc_pending = 1'b0;
        end else if (take_body(prev_byte)) begin
          if (take_body(b)) begin
            note_byte(b);
            rx_state = ST_BODY;
          end
        end
      end
      ST_DISC_CHK: begin
        if (b == (link_cfg.address_code ^ link_cfg.disc_code)) rx_state = ST_DISC_END;
        else if (b == link_cfg.flag_code) rx_state = ST_ADDR;
        else rx_state = ST_HUNT;
      end
      ST_DISC_END: begin
        if (b == link_cfg.flag_code) add_result(EV_DISC, 8'h00, 1'b0, 9'd0);
        rx_state = ST_HUNT;
      end
      default: begin
        if (b == link_cfg.flag_code) rx_state = ST_ADDR;
        else rx_state = ST_HUNT;
        body_len = 0;
      end
    endcase
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  // Offers one line byte, with random gaps, and records what it must cause.
  task automatic send_byte(input logic [7:0] b, input bit typed, input res_t typed_res);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_line_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_line_byte(b);
    if (typed) expected_events.push_back(typed_res);
    else foreach (step_results[i]) expected_events.push_back(step_results[i]);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Waits until every expected result has left, then lets the block settle.
  task automatic wait_drained();
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_FLAG:         link_cfg.flag_code    = data;
      CFG_ADDRESS:      link_cfg.address_code = data;
      CFG_ESCAPE:       link_cfg.escape_code  = data;
      CFG_SET:          link_cfg.set_code     = data;
      CFG_INFO:         link_cfg.info_code    = data;
      CFG_FINAL:        link_cfg.final_code   = data;
      CFG_DISC:         link_cfg.disc_code    = data;
      CFG_ACCEPT_FINAL: link_cfg.accept_final = data[0];
      default: ;
    endcase
  endtask

  task automatic load_config(input cfg_t c);
    wait_drained();
    write_register(CFG_FLAG, c.flag_code);
    write_register(CFG_ADDRESS, c.address_code);
    write_register(CFG_ESCAPE, c.escape_code);
    write_register(CFG_SET, c.set_code);
    write_register(CFG_INFO, c.info_code);
    write_register(CFG_FINAL, c.final_code);
    write_register(CFG_DISC, c.disc_code);
    write_register(CFG_ACCEPT_FINAL, {7'd0, c.accept_final});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A byte that means something to the parser under the current setting.
  function automatic logic [7:0] special_byte();
    case ($urandom_range(5))
      0: return link_cfg.flag_code;
      1: return link_cfg.escape_code;
      2: return link_cfg.flag_code ^ STUFF_MASK;
      3: return link_cfg.escape_code ^ STUFF_MASK;
      4: return link_cfg.address_code ^ link_cfg.info_code;
      default: return link_cfg.address_code ^ link_cfg.final_code;
    endcase
  endfunction

  // One random frame (information, SET or DISC, sometimes corrupted) or a
  // short burst of line noise, sent byte by byte.
  task automatic send_random_sequence();
    logic [7:0] seq[$];
    logic [7:0] ctrl;
    logic [7:0] chk;
    logic [7:0] d;
    int         pick;
    int         body_n;
    int         pos;
    res_t       none;
    none = '0;
    pick = $urandom_range(99);
    if (pick < 90) begin
      seq.push_back(link_cfg.flag_code);
      seq.push_back(link_cfg.address_code);
      if (pick < 60) begin
        ctrl = ($urandom_range(99) < 30) ? link_cfg.final_code : link_cfg.info_code;
        chk  = link_cfg.address_code ^ ctrl;
        if ($urandom_range(99) < 15)
          chk = link_cfg.address_code ^
                ($urandom_range(1) ? link_cfg.final_code : link_cfg.info_code);
        seq.push_back(ctrl);
        seq.push_back(chk);
        body_n = ($urandom_range(99) < 2) ? $urandom_range(250, 258) : $urandom_range(0, 12);
        for (int i = 0; i < body_n; i++) begin
          d = ($urandom_range(99) < 30) ? special_byte() : 8'($urandom_range(255));
          if (d == link_cfg.flag_code || d == link_cfg.escape_code) begin
            seq.push_back(link_cfg.escape_code);
            seq.push_back(d ^ STUFF_MASK);
          end else begin
            seq.push_back(d);
          end
        end
        seq.push_back(link_cfg.address_code ^
                      ($urandom_range(1) ? link_cfg.final_code : link_cfg.info_code));
      end else if (pick < 75) begin
        seq.push_back(link_cfg.set_code);
        seq.push_back(link_cfg.address_code ^ link_cfg.set_code);
      end else begin
        seq.push_back(link_cfg.disc_code);
        seq.push_back(link_cfg.address_code ^ link_cfg.disc_code);
      end
      seq.push_back(link_cfg.flag_code);
      // Corrupt one byte of a fraction of the frames.
      if ($urandom_range(99) < 15) begin
        pos = $urandom_range(1, seq.size() - 1);
        seq[pos] = $urandom_range(1) ? link_cfg.flag_code : 8'($urandom_range(255));
      end
    end else begin
      repeat ($urandom_range(1, 4))
        seq.push_back($urandom_range(1) ? special_byte() : 8'($urandom_range(255)));
    end
    foreach (seq[i]) begin
      send_byte(seq[i], 1'b0, none);
      random_sent++;
      if (random_sent == HOLD_AT_ITEM) stall_request = 1'b1;
      if (random_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 45;
      end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end
  endtask

  // Result consumer: random back-pressure plus one long hold-off.
  initial begin
    forever begin
      @(negedge clk);
      if (stall_request && !stall_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        stall_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compares each result beat with the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        if (error_count < REPORT_LIMIT)
          $display("Unexpected result: kind %0d payload %0h type %0d length %0d last %0d",
                   out_event_kind, out_payload, out_frame_type, out_frame_length,
                   out_last);
        error_count++;
      end else begin
        want = expected_events.pop_front();
        if (out_event_kind !== want.event_kind || out_payload !== want.payload ||
            out_frame_type !== want.frame_type ||
            out_frame_length !== want.frame_length || out_last !== want.last) begin
          if (error_count < REPORT_LIMIT)
            $display("Mismatch at %0t: expected %0d/%0h/%0d/%0d/%0d got %0d/%0h/%0d/%0d/%0d",
                     $realtime, want.event_kind, want.payload, want.frame_type,
                     want.frame_length, want.last, out_event_kind, out_payload,
                     out_frame_type, out_frame_length, out_last);
          error_count++;
        end
      end
    end
  end

  // Stimulus: directed script, a frame that overflows, then random phases.
  initial begin
    res_t        typed_res;
    script_row_t row;
    cfg_t        phase_cfg;
    logic [63:0] raw;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      row       = script[i];
      typed_res = '{event_kind: row.kind, payload: 8'h00, frame_type: 1'b0,
                    frame_length: row.length, last: 1'b1};
      send_byte(row.line_byte, row.typed, typed_res);
    end

    // The body byte past the length limit reports overflow.
    typed_res = '0;
    send_byte(link_cfg.flag_code, 1'b0, typed_res);
    send_byte(link_cfg.address_code, 1'b0, typed_res);
    send_byte(link_cfg.info_code, 1'b0, typed_res);
    send_byte(link_cfg.address_code ^ link_cfg.info_code, 1'b0, typed_res);
    for (int i = 0; i < BODY_LIMIT; i++)
      send_byte(8'(8'h80 + i % 64), 1'b0, typed_res);
    typed_res = '{event_kind: EV_OVERFLOW, payload: 8'h00, frame_type: 1'b0,
                  frame_length: 9'd0, last: 1'b1};
    send_byte(8'hC0, 1'b1, typed_res);
    release_input();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: phase_cfg = '{8'h7E, 8'h03, 8'h7D, 8'h03, 8'h00, 8'h40, 8'h0B, 1'b1};
        1: phase_cfg = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01, 1'b1};
        2: phase_cfg = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 1'b0};
        PHASE_COUNT - 1: phase_cfg = RESET_CFG;
        default: begin
          raw       = {$urandom, $urandom};
          phase_cfg = raw[56:0];
        end
      endcase
      load_config(phase_cfg);
      while (random_sent < (p + 1) * PHASE_ITEMS) send_random_sequence();
      release_input();
    end

    while (expected_events.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    error_count += expected_events.size();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/sfr_pkg.sv
rtl/sfr_parser.sv
rtl/sfr_out_queue.sv
rtl/stuffed_frame_receiver.sv
verif/stuffed_frame_receiver_tb.sv
